[rtl/core/binning_autocorrelation_estimator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the binning autocorrelation estimator
// Both macros expect clk and rst_n to be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef BINNING_AUTOCORRELATION_ESTIMATOR_MACROS_SVH
`define BINNING_AUTOCORRELATION_ESTIMATOR_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define BAE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold whenever the antecedent holds.
`define BAE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/bae_pkg.sv]
// ----------------------------------------------------------------------------
// bae_pkg
// Shared types and constants of the binning autocorrelation estimator.
// ----------------------------------------------------------------------------
package bae_pkg;

  localparam int MAX_CH   = 4;
  localparam int CH_W     = 2;
  localparam int SMP_W    = 16;
  localparam int NB_W     = 13;
  localparam int DW       = 128;
  localparam int QW       = 64;
  localparam int VAR_W    = 47;
  localparam int TAU_W    = 32;
  localparam int STS_W    = 2;

  localparam logic [NB_W-1:0]  NUM_BINS_RESET = NB_W'(16);
  localparam logic [STS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STATUS_FEW     = 2'd1;
  localparam logic [STS_W-1:0] STATUS_ZERO    = 2'd2;

  typedef enum logic [3:0] {
    STEP_BSIZE,
    STEP_NB,
    STEP_BINSQ,
    STEP_SV1,
    STEP_SV2,
    STEP_SV3,
    STEP_SV4,
    STEP_BV1,
    STEP_BV2,
    STEP_BV3,
    STEP_BV4,
    STEP_BV5,
    STEP_TAU1,
    STEP_TAU2
  } step_t;

  typedef struct packed {
    logic  append;
    logic  rpt_start;
    logic  step_start;
    step_t step;
    logic  chan_clr;
    logic  rd;
    logic  acc;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic step_done;
    logic nb_lt2;
    logic bin_take;
    logic sweep_done;
    logic sv_zero;
    logic out_free;
    logic last_ch;
  } sts_t;

  function automatic logic step_is_div(step_t s);
    logic r;
    case (s)
      STEP_BSIZE, STEP_NB, STEP_SV4, STEP_BV5, STEP_TAU2: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/binning_autocorrelation_estimator.sv]
// ----------------------------------------------------------------------------
// binning_autocorrelation_estimator
// Append: one word per cycle while idle (no report running), stored the cycle it is accepted.
// Report: its length is set per channel by the read/accumulate sample sweep,
// the bit-serial multiplier and the 128-step divider.
// Reset clears index and fill count and sets num_bins to 16; the store is not cleared.
// ----------------------------------------------------------------------------
module binning_autocorrelation_estimator import bae_pkg::*; #(
  parameter int CAPACITY     = 4096,
  parameter int NUM_CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [SMP_W-1:0]  in_sample_0,
  input  logic [SMP_W-1:0]  in_sample_1,
  input  logic [SMP_W-1:0]  in_sample_2,
  input  logic [SMP_W-1:0]  in_sample_3,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [NB_W-1:0]   cfg_num_bins,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CH_W-1:0]   out_channel,
  output logic [STS_W-1:0]  out_status,
  output logic [VAR_W-1:0]  out_sample_variance,
  output logic [VAR_W-1:0]  out_bin_variance,
  output logic [TAU_W-1:0]  out_tau,
  output logic              out_last
);

  cmd_t             cmd;
  sts_t             sts;
  logic [SMP_W-1:0] samples [MAX_CH];

  assign samples[0] = in_sample_0;
  assign samples[1] = in_sample_1;
  assign samples[2] = in_sample_2;
  assign samples[3] = in_sample_3;
  assign cfg_ready  = 1'b1;

  bae_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bae_datapath #(
    .CAPACITY     (CAPACITY),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_sample           (samples),
    .cfg_we              (cfg_valid),
    .cfg_num_bins        (cfg_num_bins),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_channel         (out_channel),
    .out_status          (out_status),
    .out_sample_variance (out_sample_variance),
    .out_bin_variance    (out_bin_variance),
    .out_tau             (out_tau),
    .out_last            (out_last)
  );

endmodule

[rtl/core/bae_store.sv]
// ----------------------------------------------------------------------------
// bae_store
// Per-channel sample ring memories with one write port and a registered read.
// ----------------------------------------------------------------------------
module bae_store import bae_pkg::*; #(
  parameter int CAPACITY     = 4096,
  parameter int NUM_CHANNELS = 4,
  parameter int AW           = 12
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [SMP_W-1:0] wr_data [MAX_CH],
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic [CH_W-1:0]  rd_ch,
  output logic [SMP_W-1:0] rd_data
);

  logic [SMP_W-1:0] q_r [MAX_CH];

  for (genvar g = 0; g < MAX_CH; g++) begin : g_ch
    if (g < NUM_CHANNELS) begin : g_mem
      logic [SMP_W-1:0] mem [CAPACITY];
      always_ff @(posedge clk) begin
        if (wr_en) begin
          mem[wr_addr] <= wr_data[g];
        end
        if (rd_en) begin
          q_r[g] <= mem[rd_addr];
        end
      end
    end else begin : g_none
      assign q_r[g] = '0;
    end
  end

  assign rd_data = q_r[rd_ch];

endmodule

[rtl/core/bae_datapath.sv]
// ----------------------------------------------------------------------------
// bae_datapath
// Sample store, running sums, shared multiplier and divider, result register.
// ----------------------------------------------------------------------------
`include "binning_autocorrelation_estimator_macros.svh"

module bae_datapath import bae_pkg::*; #(
  parameter int CAPACITY     = 4096,
  parameter int NUM_CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [SMP_W-1:0]  in_sample [MAX_CH],
  input  logic              cfg_we,
  input  logic [NB_W-1:0]   cfg_num_bins,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [CH_W-1:0]   out_channel,
  output logic [STS_W-1:0]  out_status,
  output logic [VAR_W-1:0]  out_sample_variance,
  output logic [VAR_W-1:0]  out_bin_variance,
  output logic [TAU_W-1:0]  out_tau,
  output logic              out_last
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int SW  = SMP_W + 1 + AW;
  localparam int S2W = 2 * SMP_W + AW;

  logic [NB_W-1:0]   num_bins_r;
  logic [AW-1:0]     widx_r;
  logic [CW-1:0]     fill_r;
  logic [CH_W-1:0]   ch_r;
  logic [CW-1:0]     bsize_r, nb_r, pos_r, bpos_r, k_r;
  logic signed [SW-1:0] s_r, t_r, bacc_r;
  logic [S2W-1:0]    s2_r;
  logic [SW-1:0]     bsq_r;
  logic [DW-1:0]     u_r, acc_a_r;
  logic [QW-1:0]     den_r;
  logic [VAR_W-1:0]  sv_r, bv_r;
  logic [TAU_W-1:0]  tau_r;
  logic              out_valid_r;

  logic [SMP_W-1:0]  rd_data;

  bae_store #(
    .CAPACITY     (CAPACITY),
    .NUM_CHANNELS (NUM_CHANNELS),
    .AW           (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.append),
    .wr_addr (widx_r),
    .wr_data (in_sample),
    .rd_en   (cmd.rd),
    .rd_addr (pos_r[AW-1:0]),
    .rd_ch   (ch_r),
    .rd_data (rd_data)
  );

  // Shared shift-and-add multiplier.
  logic [DW-1:0] ma_r, mp_r, mul_a;
  logic [QW-1:0] mb_r, mul_b;
  logic          mul_busy_r, mul_done;

  // Shared restoring divider, one quotient bit per cycle.
  logic [DW-1:0] dn_r, div_n;
  logic [QW-1:0] dd_r, rem_r, dq_r, div_d, rem_sh, qres;
  logic [6:0]    dcnt_r;
  logic          over_r, div_busy_r, div_done_r, take;
  step_t         act_r;

  logic [SW-1:0] s_mag, t_mag;
  logic signed [SMP_W-1:0] x;
  logic signed [2*SMP_W-1:0] sq;
  logic signed [SW-1:0] bsum;
  logic          bin_end, counted;

  assign s_mag   = s_r[SW-1] ? SW'(-s_r) : SW'(s_r);
  assign t_mag   = t_r[SW-1] ? SW'(-t_r) : SW'(t_r);
  assign x       = signed'(rd_data);
  assign sq      = x * x;
  assign bsum    = bacc_r + SW'(x);
  assign bin_end = (bpos_r == bsize_r - 1'b1);
  assign counted = (k_r < nb_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = '0;
    case (cmd.step)
      STEP_BSIZE: begin
        div_n = DW'(CAPACITY);
        div_d = QW'(num_bins_r);
      end
      STEP_NB: begin
        div_n = DW'(fill_r);
        div_d = QW'(bsize_r);
      end
      STEP_BINSQ: begin
        mul_a = DW'(bsq_r);
        mul_b = QW'(bsq_r);
      end
      STEP_SV1: begin
        mul_a = DW'(s2_r);
        mul_b = QW'(fill_r);
      end
      STEP_SV2: begin
        mul_a = DW'(s_mag);
        mul_b = QW'(s_mag);
      end
      STEP_SV3: begin
        mul_a = DW'(fill_r);
        mul_b = QW'(fill_r);
      end
      STEP_BV1: begin
        mul_a = u_r;
        mul_b = QW'(nb_r);
      end
      STEP_BV2: begin
        mul_a = DW'(t_mag);
        mul_b = QW'(t_mag);
      end
      STEP_BV3: begin
        mul_a = DW'(nb_r);
        mul_b = QW'(bsize_r);
      end
      STEP_BV4: begin
        mul_a = DW'(den_r);
        mul_b = den_r;
      end
      STEP_TAU1: begin
        mul_a = DW'(bv_r);
        mul_b = QW'(bsize_r);
      end
      STEP_SV4, STEP_BV5: begin
        div_n = acc_a_r;
        div_d = den_r;
      end
      STEP_TAU2: begin
        div_n = acc_a_r;
        div_d = QW'(sv_r);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_done = mul_busy_r && (mb_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
    end else if (cmd.step_start && !step_is_div(cmd.step)) begin
      ma_r       <= mul_a;
      mb_r       <= mul_b;
      mp_r       <= '0;
      mul_busy_r <= 1'b1;
    end else if (mul_busy_r) begin
      if (mb_r == '0) begin
        mul_busy_r <= 1'b0;
      end else begin
        if (mb_r[0]) begin
          mp_r <= mp_r + ma_r;
        end
        ma_r <= ma_r << 1;
        mb_r <= mb_r >> 1;
      end
    end
  end

  assign rem_sh = {rem_r[QW-2:0], dn_r[DW-1]};
  assign take   = rem_r[QW-1] || (rem_sh >= dd_r);
  assign qres   = over_r ? '1 : dq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
    end else begin
      div_done_r <= 1'b0;
      if (cmd.step_start && step_is_div(cmd.step)) begin
        dn_r       <= div_n;
        dd_r       <= div_d;
        rem_r      <= '0;
        dq_r       <= '0;
        over_r     <= 1'b0;
        dcnt_r     <= 7'd127;
        div_busy_r <= 1'b1;
      end else if (div_busy_r) begin
        dn_r  <= dn_r << 1;
        rem_r <= take ? rem_sh - dd_r : rem_sh;
        if (dcnt_r[6]) begin
          over_r <= over_r | take;
        end else begin
          dq_r <= {dq_r[QW-2:0], take};
        end
        dcnt_r <= dcnt_r - 1'b1;
        if (dcnt_r == '0) begin
          div_busy_r <= 1'b0;
          div_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r  <= NUM_BINS_RESET;
      widx_r      <= '0;
      fill_r      <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_bins_r <= cfg_num_bins;
      end
      if (cmd.append) begin
        widx_r <= (widx_r == AW'(CAPACITY - 1)) ? '0 : widx_r + 1'b1;
        if (fill_r != CW'(CAPACITY)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (cmd.step_start) begin
        act_r <= cmd.step;
      end
      if (cmd.rpt_start) begin
        ch_r <= '0;
      end
      if (cmd.chan_clr) begin
        s_r    <= '0;
        s2_r   <= '0;
        t_r    <= '0;
        u_r    <= '0;
        bacc_r <= '0;
        pos_r  <= '0;
        bpos_r <= '0;
        k_r    <= '0;
        sv_r   <= '0;
        bv_r   <= '0;
        tau_r  <= '0;
      end
      if (cmd.acc) begin
        s_r   <= s_r + SW'(x);
        s2_r  <= s2_r + S2W'($unsigned(sq));
        pos_r <= pos_r + 1'b1;
        if (bin_end) begin
          bpos_r <= '0;
          k_r    <= k_r + 1'b1;
          bacc_r <= '0;
          if (counted) begin
            t_r   <= t_r + bsum;
            bsq_r <= bsum[SW-1] ? SW'(-bsum) : SW'(bsum);
          end
        end else begin
          bpos_r <= bpos_r + 1'b1;
          bacc_r <= bsum;
        end
      end
      if (mul_done || div_done_r) begin
        case (act_r)
          STEP_BSIZE: bsize_r <= (num_bins_r == '0) ? '0 : qres[CW-1:0];
          STEP_NB: begin
            if (bsize_r == '0) begin
              nb_r <= '0;
            end else if (qres > QW'(num_bins_r)) begin
              nb_r <= CW'(num_bins_r);
            end else begin
              nb_r <= qres[CW-1:0];
            end
          end
          STEP_BINSQ: u_r <= u_r + mp_r;
          STEP_SV1, STEP_BV1: acc_a_r <= mp_r;
          STEP_SV2, STEP_BV2: acc_a_r <= (acc_a_r - mp_r) << 16;
          STEP_SV3, STEP_BV3, STEP_BV4: den_r <= mp_r[QW-1:0];
          STEP_SV4: sv_r <= (qres > QW'({VAR_W{1'b1}})) ? '1 : qres[VAR_W-1:0];
          STEP_BV5: bv_r <= (qres > QW'({VAR_W{1'b1}})) ? '1 : qres[VAR_W-1:0];
          STEP_TAU1: acc_a_r <= mp_r << 16;
          STEP_TAU2: tau_r <= (qres > QW'({TAU_W{1'b1}})) ? '1 : qres[TAU_W-1:0];
          default: acc_a_r <= acc_a_r;
        endcase
      end
      if (cmd.emit) begin
        out_valid_r         <= 1'b1;
        out_channel         <= ch_r;
        out_sample_variance <= sv_r;
        out_bin_variance    <= bv_r;
        out_tau             <= tau_r;
        out_last            <= (ch_r == CH_W'(NUM_CHANNELS - 1));
        if (nb_r < CW'(2)) begin
          out_status <= STATUS_FEW;
        end else if (sv_r == '0) begin
          out_status <= STATUS_ZERO;
        end else begin
          out_status <= STATUS_OK;
        end
        ch_r <= ch_r + 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign sts.step_done  = mul_done || div_done_r;
  assign sts.nb_lt2     = (nb_r < CW'(2));
  assign sts.bin_take   = bin_end && counted;
  assign sts.sweep_done = (pos_r == fill_r);
  assign sts.sv_zero    = (sv_r == '0);
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.last_ch    = (ch_r == CH_W'(NUM_CHANNELS - 1));

  `BAE_ASSERT_ALWAYS(a_fill_cap, fill_r <= CW'(CAPACITY), "fill count above capacity")
  `BAE_ASSERT_ALWAYS(a_widx_range, widx_r <= AW'(CAPACITY - 1), "write index out of range")
  `BAE_ASSERT_ALWAYS(a_units_excl, !(mul_busy_r && div_busy_r), "multiplier and divider both busy")
  `BAE_ASSERT_IMPL(a_start_idle, cmd.step_start, !mul_busy_r && !div_busy_r, "step start while busy")

endmodule

[rtl/core/bae_ctrl.sv]
// ----------------------------------------------------------------------------
// bae_ctrl
// Sequencer for appends, report sweeps and the arithmetic step chain.
// ----------------------------------------------------------------------------
module bae_ctrl import bae_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_func,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_CHAN,
    ST_RD,
    ST_ACC,
    ST_NEXT,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.step  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_func) begin
            cmd.append = 1'b1;
          end else begin
            cmd.rpt_start = 1'b1;
            step_nxt      = STEP_BSIZE;
            state_nxt     = ST_START;
          end
        end
      end
      ST_START: begin
        cmd.step_start = 1'b1;
        state_nxt      = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.step_done) begin
          state_nxt = ST_START;
          case (step_r)
            STEP_BSIZE: step_nxt = STEP_NB;
            STEP_NB:    state_nxt = ST_CHAN;
            STEP_BINSQ: state_nxt = ST_NEXT;
            STEP_SV1:   step_nxt = STEP_SV2;
            STEP_SV2:   step_nxt = STEP_SV3;
            STEP_SV3:   step_nxt = STEP_SV4;
            STEP_SV4:   step_nxt = STEP_BV1;
            STEP_BV1:   step_nxt = STEP_BV2;
            STEP_BV2:   step_nxt = STEP_BV3;
            STEP_BV3:   step_nxt = STEP_BV4;
            STEP_BV4:   step_nxt = STEP_BV5;
            STEP_BV5: begin
              if (sts.sv_zero) begin
                state_nxt = ST_EMIT;
              end else begin
                step_nxt = STEP_TAU1;
              end
            end
            STEP_TAU1:  step_nxt = STEP_TAU2;
            default:    state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_CHAN: begin
        cmd.chan_clr = 1'b1;
        state_nxt    = sts.nb_lt2 ? ST_EMIT : ST_RD;
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (sts.bin_take) begin
          step_nxt  = STEP_BINSQ;
          state_nxt = ST_START;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (sts.sweep_done) begin
          step_nxt  = STEP_SV1;
          state_nxt = ST_START;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last_ch ? ST_IDLE : ST_CHAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STEP_BSIZE;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule
